[rtl/pcgbg_pkg.sv]
// Shared types and constants for the bounded PCG32 generator.
`default_nettype none

package pcgbg_pkg;

   // Splitmix64 and LCG constants.
   localparam logic [63:0] SPLITMIX_INC = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] LCG_MULT     = 64'h5851_F42D_4C95_7F2D;
   localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

   // Rejection cap: the last allowed try of a draw.
   localparam logic [7:0]  LAST_TRY     = 8'd255;

   // Input mode codes.
   localparam logic        MODE_RESEED  = 1'b0;
   localparam logic        MODE_DRAW    = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0]  CSR_BASE_SEED = 2'd0;
   localparam logic [1:0]  CSR_STREAM_ID = 2'd1;

   // Request to the serial multiplier: product = a * b + addend (mod 2^64).
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] addend;
   } mul_req_type;

   // Request to the serial divider: remainder = dividend mod divisor.
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RS_MAT,
      ST_RS_LA,
      ST_RS_WA,
      ST_RS_WB,
      ST_RS_LADV,
      ST_RS_WADV,
      ST_DR_WAIT,
      ST_DR_MOD,
      ST_DONE
   } fsm_type;

endpackage

`default_nettype wire

[rtl/pcgbg_mul.sv]
// Digit-serial 64-bit multiply-add, two multiplier bits per cycle.
`default_nettype none

module pcgbg_mul
   import pcgbg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mul_req_type mul_req,
   output logic             mul_busy,
   output logic [63:0]      mul_prod
);

   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [63:0] pp_lo, pp_hi;

   // One radix-4 step: add the two partial products selected by the low digit.
   always_comb begin
      pp_lo  = a_ff[0] ? b_ff : 64'd0;
      pp_hi  = a_ff[1] ? {b_ff[62:0], 1'b0} : 64'd0;
      a_in   = a_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (mul_req.start) begin
         a_in    = mul_req.a;
         b_in    = mul_req.b;
         acc_in  = mul_req.addend;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + pp_lo + pp_hi;
         a_in   = {2'b00, a_ff[63:2]};
         b_in   = {b_ff[61:0], 2'b00};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Data shift registers.
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign mul_busy = busy_ff;
   assign mul_prod = acc_ff;

endmodule

`default_nettype wire

[rtl/pcgbg_div.sv]
// Bit-serial restoring remainder unit for 32-bit operands.
`default_nettype none

module pcgbg_div
   import pcgbg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output logic             div_busy,
   output logic [31:0]      div_rem
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] dd_ff, dd_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;
   logic [32:0] diff;

   // One dividend bit enters the partial remainder per cycle.
   always_comb begin
      trial   = {rem_ff, dd_ff[31]};
      diff    = trial - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      dd_in   = dd_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (div_req.start) begin
         rem_in  = 32'd0;
         dd_in   = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = diff[32] ? trial[31:0] : diff[31:0];
         dd_in  = {dd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dd_ff  <= dd_in;
      dvs_ff <= dvs_in;
   end

   assign div_busy = busy_ff;
   assign div_rem  = rem_ff;

endmodule

`default_nettype wire

[rtl/pcg32_bounded_generator_top.sv]
// Top level of the bounded PCG32 generator with splitmix64 reseeding.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  req     | req_valid req_ready req_mode req_room_key    | in
//          | req_bound                                    |
//  rsp     | rsp_valid rsp_ready rsp_value                | out
//  csr     | csr_valid csr_ready csr_index csr_wdata      | in
//
// One item is worked on at a time, through a serial multiplier and a serial remainder unit.
// A reseed runs six multiplies in sequence.
// A draw runs one advance per try (the threshold remainder overlaps the first try),
// then the final remainder, then posts the item; a zero bound posts zero directly.
// Reset is synchronous; it clears the generator state and sets stream_id to 7.
// A result waiting on rsp_ready holds the sequencer; csr writes are always taken.
`default_nettype none

module pcg32_bounded_generator_top
   import pcgbg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [31:0] req_room_key,
   input  wire logic [31:0] req_bound,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_value,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   fsm_type     fsm_ff, fsm_in;
   logic [63:0] base_seed_ff;
   logic [31:0] stream_id_ff;
   logic [63:0] gen_state_ff, gen_state_in;
   logic [63:0] gen_inc_ff, gen_inc_in;
   logic [63:0] old_ff, old_in;
   logic [63:0] mat_ff, mat_in;
   logic [63:0] init_ff, init_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] bound_ff, bound_in;
   logic [31:0] res_ff, res_in;
   logic [7:0]  tries_ff, tries_in;
   logic        second_ff, second_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;

   mul_req_type mul_req;
   logic        mul_busy;
   logic [63:0] mul_prod;
   div_req_type div_req;
   logic        div_busy;
   logic [31:0] div_rem;

   logic [63:0] mix_out;
   logic [31:0] draw_val;

   // XSH-RR output permutation of the state before an advance.
   function automatic logic [31:0] pcg_output(input logic [63:0] old);
      logic [31:0] xs;
      logic [63:0] dbl;
      xs  = 32'(((old >> 18) ^ old) >> 27);
      dbl = {xs, xs} >> old[63:59];
      return dbl[31:0];
   endfunction

   pcgbg_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .mul_req  (mul_req),
      .mul_busy (mul_busy),
      .mul_prod (mul_prod)
   );

   pcgbg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_busy (div_busy),
      .div_rem  (div_rem)
   );

   assign mix_out   = mul_prod ^ (mul_prod >> 31);
   assign draw_val  = pcg_output(old_ff);
   assign req_ready = (fsm_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // Sequencer: next state, unit launches and datapath register updates.
   always_comb begin
      fsm_in       = fsm_ff;
      gen_state_in = gen_state_ff;
      gen_inc_in   = gen_inc_ff;
      old_in       = old_ff;
      mat_in       = mat_ff;
      init_in      = init_ff;
      key_in       = key_ff;
      bound_in     = bound_ff;
      res_in       = res_ff;
      tries_in     = tries_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;

      mul_req.start    = 1'b0;
      mul_req.a        = gen_state_ff;
      mul_req.b        = LCG_MULT;
      mul_req.addend   = gen_inc_ff;
      div_req.start    = 1'b0;
      div_req.dividend = draw_val;
      div_req.divisor  = bound_ff;

      // The output register empties when the item is taken.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (fsm_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in   = req_room_key;
               bound_in = req_bound;
               if (req_mode == MODE_RESEED) begin
                  // Stream number times the splitmix increment.
                  mul_req.start  = 1'b1;
                  mul_req.a      = {32'd0, stream_id_ff};
                  mul_req.b      = SPLITMIX_INC;
                  mul_req.addend = 64'd0;
                  second_in      = 1'b0;
                  fsm_in         = ST_RS_MAT;
               end else if (req_bound == 32'd0) begin
                  res_in = 32'd0;
                  fsm_in = ST_DONE;
               end else begin
                  // First advance runs beside the threshold remainder.
                  mul_req.start    = 1'b1;
                  old_in           = gen_state_ff;
                  div_req.start    = 1'b1;
                  div_req.dividend = 32'd0 - req_bound;
                  div_req.divisor  = req_bound;
                  tries_in         = 8'd0;
                  fsm_in           = ST_DR_WAIT;
               end
            end
         end
         ST_RS_MAT: begin
            if (!mul_busy) begin
               mat_in = (base_seed_ff ^ mul_prod ^ {key_ff, key_ff}) + SPLITMIX_INC;
               fsm_in = ST_RS_LA;
            end
         end
         ST_RS_LA: begin
            mul_req.start  = 1'b1;
            mul_req.a      = mat_ff ^ (mat_ff >> 30);
            mul_req.b      = MIX_MUL_A;
            mul_req.addend = 64'd0;
            fsm_in         = ST_RS_WA;
         end
         ST_RS_WA: begin
            if (!mul_busy) begin
               mul_req.start  = 1'b1;
               mul_req.a      = mul_prod ^ (mul_prod >> 27);
               mul_req.b      = MIX_MUL_B;
               mul_req.addend = 64'd0;
               fsm_in         = ST_RS_WB;
            end
         end
         ST_RS_WB: begin
            if (!mul_busy) begin
               if (!second_ff) begin
                  // First splitmix output is the initial state.
                  init_in   = mix_out;
                  second_in = 1'b1;
                  mat_in    = mat_ff + SPLITMIX_INC;
                  fsm_in    = ST_RS_LA;
               end else begin
                  // Advance from zero gives the increment; then add the seed.
                  gen_inc_in   = {mix_out[62:0], 1'b1};
                  gen_state_in = {mix_out[62:0], 1'b1} + init_ff;
                  fsm_in       = ST_RS_LADV;
               end
            end
         end
         ST_RS_LADV: begin
            mul_req.start = 1'b1;
            fsm_in        = ST_RS_WADV;
         end
         ST_RS_WADV: begin
            if (!mul_busy) begin
               gen_state_in = mul_prod;
               res_in       = 32'd0;
               fsm_in       = ST_DONE;
            end
         end
         ST_DR_WAIT: begin
            if (!mul_busy && !div_busy) begin
               gen_state_in = mul_prod;
               if ((draw_val >= div_rem) || (tries_ff == LAST_TRY)) begin
                  div_req.start = 1'b1;
                  fsm_in        = ST_DR_MOD;
               end else begin
                  // Rejected: advance again from the new state.
                  mul_req.start = 1'b1;
                  mul_req.a     = mul_prod;
                  old_in        = mul_prod;
                  tries_in      = tries_ff + 8'd1;
               end
            end
         end
         ST_DR_MOD: begin
            if (!div_busy) begin
               res_in = div_rem;
               fsm_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               fsm_in       = ST_IDLE;
            end
         end
         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   // Control and generator state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gen_state_ff <= 64'd0;
         gen_inc_ff   <= 64'd0;
         tries_ff     <= 8'd0;
         second_ff    <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         rsp_valid_ff <= rsp_valid_in;
         gen_state_ff <= gen_state_in;
         gen_inc_ff   <= gen_inc_in;
         tries_ff     <= tries_in;
         second_ff    <= second_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_seed_ff <= 64'd0;
         stream_id_ff <= 32'd7;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE_SEED: base_seed_ff <= csr_wdata;
            CSR_STREAM_ID: stream_id_ff <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      old_ff       <= old_in;
      mat_ff       <= mat_in;
      init_ff      <= init_in;
      key_ff       <= key_in;
      bound_ff     <= bound_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

`default_nettype wire
